[rtl/rgpc_pkg.sv]
// shared constants and types of the radial gradient pixel colour block
`default_nettype none
package rgpc_pkg;

   localparam int COORD_BITS = 12;
   localparam int COLOR_W    = 8;
   localparam int SIZE_W     = 12;
   localparam int PROF_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int FRAC_W = 16;
   localparam int QINT_W = 16;
   localparam int Q_W    = QINT_W + 2 * FRAC_W;
   localparam int R_W    = 8 + FRAC_W;
   localparam int D2_W   = 2 * COORD_BITS + 1;
   localparam int DEN_W  = 2 * SIZE_W + 1;
   localparam int SQ_N   = Q_W / 2;
   localparam int RT_W   = Q_W / 2;
   localparam int SR_W   = RT_W + 2;
   localparam int CMP_W  = 64;
   localparam int W_W    = 31;
   localparam int T_W    = 33;
   localparam int NUM_W  = 36;

   // pipeline: input, squares, divider set-up, divider, root, ratio and blend
   localparam int N_STG    = 3 + Q_W + SQ_N + 11;
   localparam int ST_DIV   = 2 + Q_W;
   localparam int ST_RATIO = N_STG - 3;

   localparam logic [R_W-1:0] RATIO_MAX = R_W'(255) << FRAC_W;
   localparam logic [16:0]    ONE_Q16   = 17'h10000;
   localparam logic [16:0]    HALF_Q16  = 17'h08000;
   localparam logic [17:0]    TWO_Q16   = 18'h20000;
   localparam logic [15:0]    SAT_LIN_K = 16'd65025;
   localparam logic [7:0]     SAT_SQ_K  = 8'd255;

   localparam logic [T_W-1:0] K5 = 33'd27709939;
   localparam logic [T_W-1:0] HK [0:3] = '{33'd252684340, 33'd1433727482,
                                           33'd4358008962, 33'd5298703516};
   localparam logic [63:0] HV_ROUND = 64'h0000_4000_0000_0000;

   localparam logic [PROF_W-1:0] PROF_SQUARED = 2'd1;
   localparam logic [PROF_W-1:0] PROF_SINE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_START_RED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_GREEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_BLUE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_RED     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_END_GREEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_END_BLUE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PROFILE     = 3'd7;

   typedef struct packed {
      logic zero;
      logic sat_lin;
      logic sat_sq;
   } flags_type;

   typedef struct packed {
      logic           hi;
      logic [R_W-1:0] lin;
      logic [R_W-1:0] sq;
   } pass_type;

endpackage
`default_nettype wire

[rtl/rgpc_channels.sv]
// item channel interfaces: pixel coordinates in, colour out
`default_nettype none
interface rgpc_req_if;
   import rgpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] x_pos;
   logic [COORD_BITS-1:0] y_pos;
   modport source (output valid, output x_pos, output y_pos, input ready);
   modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

interface rgpc_rsp_if;
   import rgpc_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red_out;
   logic [COLOR_W-1:0] green_out;
   logic [COLOR_W-1:0] blue_out;
   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface
`default_nettype wire

[rtl/radial_gradient_pixel_color_top.sv]
// radial gradient pixel colour: top level pipeline
`default_nettype none
// takes one pixel (x_pos, y_pos) per cycle and returns its colour in a radial
// gradient from the start colour at the origin to the end colour at the
// corner (size, size). a fully pipelined datapath of 86 register stages: the
// result is presented from the last stage and a new item is accepted every
// cycle while the result side takes items. the depth is set by
// the restoring divider (one quotient bit per stage, 48 stages) and the
// square root (two bits per stage, 24 stages); the cosine polynomial takes
// one multiply per stage.
// when the result side stalls, the whole pipeline holds; the input stage
// still takes one item if it is empty. configuration registers are written
// through the csr port and must only change while no item is in flight.
module radial_gradient_pixel_color_top (
   input  wire                              clock,
   input  wire                              reset,
   rgpc_req_if.sink                         req_ch,
   rgpc_rsp_if.source                       rsp_ch,
   input  wire                              csr_we,
   input  wire [rgpc_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  wire [rgpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rgpc_pkg::*;

   // ---------------------------------------------------------------- config
   logic [COLOR_W-1:0] start_ff [0:2];
   logic [COLOR_W-1:0] end_ff   [0:2];
   logic [SIZE_W-1:0]  size_ff;
   logic [PROF_W-1:0]  profile_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff[0] <= 8'd255;
         start_ff[1] <= 8'd255;
         start_ff[2] <= 8'd255;
         end_ff[0]   <= 8'd0;
         end_ff[1]   <= 8'd255;
         end_ff[2]   <= 8'd0;
         size_ff     <= 12'd500;
         profile_ff  <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            REG_START_RED:   start_ff[0] <= csr_wdata[COLOR_W-1:0];
            REG_START_GREEN: start_ff[1] <= csr_wdata[COLOR_W-1:0];
            REG_START_BLUE:  start_ff[2] <= csr_wdata[COLOR_W-1:0];
            REG_END_RED:     end_ff[0]   <= csr_wdata[COLOR_W-1:0];
            REG_END_GREEN:   end_ff[1]   <= csr_wdata[COLOR_W-1:0];
            REG_END_BLUE:    end_ff[2]   <= csr_wdata[COLOR_W-1:0];
            REG_SIZE:        size_ff     <= csr_wdata[SIZE_W-1:0];
            REG_PROFILE:     profile_ff  <= csr_wdata[PROF_W-1:0];
            default: ;
         endcase
      end
   end

   // denominator 2*s*s and the saturation limits, retimed off the config
   logic [DEN_W-1:0]    den_ff;
   logic [DEN_W+15:0]   thr_lin_ff;
   logic [DEN_W+7:0]    thr_sq_ff;

   always_ff @(posedge clock) begin
      den_ff     <= {(DEN_W-1)'(size_ff) * (DEN_W-1)'(size_ff), 1'b0};
      thr_lin_ff <= SAT_LIN_K * den_ff;
      thr_sq_ff  <= SAT_SQ_K * den_ff;
   end

   // ---------------------------------------------------------------- control
   logic             vld_ff [0:N_STG-1];
   logic             adv;
   logic             en0;

   // whole pipeline moves when the output is empty or being taken
   assign adv          = !vld_ff[N_STG-1] || rsp_ch.ready;
   // the input stage also fills while stalled if it holds nothing
   assign en0          = adv || !vld_ff[0];
   assign req_ch.ready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_STG; i++) vld_ff[i] <= 1'b0;
      end else begin
         if (en0) vld_ff[0] <= req_ch.valid;
         if (adv) begin
            for (int i = 1; i < N_STG; i++) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- squares
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [D2_W-1:0]       d2_ff;

   always_ff @(posedge clock) begin
      if (en0) begin
         x_ff <= req_ch.x_pos;
         y_ff <= req_ch.y_pos;
      end
      if (adv) d2_ff <= D2_W'(x_ff) * D2_W'(x_ff) + D2_W'(y_ff) * D2_W'(y_ff);
   end

   // ---------------------------------------------------------------- divider
   // floor(d2 * 2^32 / den), valid whenever the integer part stays below 65025
   logic [DEN_W-1:0]  drem_ff [0:Q_W];
   logic [QINT_W-1:0] dlo_ff  [0:Q_W];
   logic [Q_W-1:0]    dq_ff   [0:Q_W];
   flags_type         dfl_ff  [0:Q_W];
   flags_type         fl_in;

   always_comb begin
      fl_in.zero    = (d2_ff == '0);
      fl_in.sat_lin = !fl_in.zero && (CMP_W'(d2_ff) >= CMP_W'(thr_lin_ff));
      fl_in.sat_sq  = !fl_in.zero && (CMP_W'(d2_ff) >= CMP_W'(thr_sq_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         drem_ff[0] <= DEN_W'(d2_ff >> QINT_W);
         dlo_ff[0]  <= d2_ff[QINT_W-1:0];
         dq_ff[0]   <= '0;
         dfl_ff[0]  <= fl_in;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      logic [DEN_W:0]   cand;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      always_comb begin
         cand   = {drem_ff[k], dlo_ff[k][QINT_W-1]};
         ge     = (cand >= {1'b0, den_ff});
         rem_in = ge ? DEN_W'(cand - {1'b0, den_ff}) : DEN_W'(cand);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[k+1] <= rem_in;
            dlo_ff[k+1]  <= {dlo_ff[k][QINT_W-2:0], 1'b0};
            dq_ff[k+1]   <= {dq_ff[k][Q_W-2:0], ge};
            dfl_ff[k+1]  <= dfl_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------- root
   logic [SR_W-1:0] sr_rem_ff  [1:SQ_N];
   logic [RT_W-1:0] sr_root_ff [1:SQ_N];
   logic [Q_W-1:0]  sr_val_ff  [1:SQ_N];
   flags_type       sr_fl_ff   [1:SQ_N];
   logic [R_W-1:0]  sr_sq_ff   [1:SQ_N];

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      logic [SR_W-1:0] rem_p;
      logic [RT_W-1:0] root_p;
      logic [Q_W-1:0]  val_p;
      flags_type       fl_p;
      logic [R_W-1:0]  sq_p;
      logic [SR_W+1:0] cand;
      logic [SR_W+1:0] trial;
      logic            ge;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign val_p  = dq_ff[Q_W];
         assign fl_p   = dfl_ff[Q_W];
         assign sq_p   = dq_ff[Q_W][R_W+FRAC_W-1:FRAC_W];
      end else begin : g_next
         assign rem_p  = sr_rem_ff[k];
         assign root_p = sr_root_ff[k];
         assign val_p  = sr_val_ff[k];
         assign fl_p   = sr_fl_ff[k];
         assign sq_p   = sr_sq_ff[k];
      end

      always_comb begin
         cand  = {rem_p, val_p[Q_W-1:Q_W-2]};
         trial = {2'b00, root_p, 2'b01};
         ge    = (cand >= trial);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sr_rem_ff[k+1]  <= ge ? SR_W'(cand - trial) : SR_W'(cand);
            sr_root_ff[k+1] <= {root_p[RT_W-2:0], ge};
            sr_val_ff[k+1]  <= {val_p[Q_W-3:0], 2'b00};
            sr_fl_ff[k+1]   <= fl_p;
            sr_sq_ff[k+1]   <= sq_p;
         end
      end
   end

   // ---------------------------------------------------------------- ratios
   logic [R_W-1:0] lin_ff, sq_ff;
   flags_type      efl;

   assign efl = sr_fl_ff[SQ_N];

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff <= efl.zero ? '0 : (efl.sat_lin ? RATIO_MAX : R_W'(sr_root_ff[SQ_N]));
         sq_ff  <= efl.zero ? '0 : (efl.sat_sq ? RATIO_MAX : sr_sq_ff[SQ_N]);
      end
   end

   // sine phase: fold the linear ratio into [0, 1] and then about one half
   logic [16:0] ph_p;
   logic [17:0] ph_u18;
   logic [16:0] ph_u;
   logic [16:0] ph_v;
   pass_type    pf_in;
   logic [15:0] v_ff;
   pass_type    pf_ff [0:6];
   logic [W_W-1:0] w_ff [0:4];
   logic [T_W-1:0] t_ff [0:3];
   logic [16:0]    h_ff;

   always_comb begin
      ph_p      = lin_ff[16:0];
      ph_u18    = TWO_Q16 - {1'b0, ph_p};
      ph_u      = (ph_p <= ONE_Q16) ? ph_p : ph_u18[16:0];
      pf_in.hi  = (ph_u > HALF_Q16);
      ph_v      = pf_in.hi ? (ONE_Q16 - ph_u) : ph_u;
      pf_in.lin = lin_ff;
      pf_in.sq  = sq_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff     <= ph_v[15:0];
         pf_ff[0] <= pf_in;
         w_ff[0]  <= W_W'(v_ff) * W_W'(v_ff);
         pf_ff[1] <= pf_ff[0];
      end
   end

   // horner steps of the cosine series, one multiply per stage
   for (genvar m = 0; m < 4; m++) begin : g_horner
      logic [T_W-1:0] t_p;
      logic [63:0]    prod;

      if (m == 0) begin : g_first
         assign t_p = K5;
      end else begin : g_next
         assign t_p = t_ff[m-1];
      end

      assign prod = 64'(t_p) * 64'(w_ff[m]);

      always_ff @(posedge clock) begin
         if (adv) begin
            t_ff[m]    <= HK[m] - {1'b0, prod[63:32]};
            w_ff[m+1]  <= w_ff[m];
            pf_ff[m+2] <= pf_ff[m+1];
         end
      end
   end

   logic [63:0] hv_sum;
   assign hv_sum = 64'(t_ff[3]) * 64'(w_ff[4]) + HV_ROUND;

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff     <= hv_sum[63:47];
         pf_ff[6] <= pf_ff[5];
      end
   end

   // final ratio per profile; an unused profile code acts as linear
   logic [16:0]    g_raw;
   logic [16:0]    g_val;
   logic [R_W-1:0] r_in;
   logic [R_W-1:0] r_ff;

   always_comb begin
      if (pf_ff[6].hi) g_raw = (h_ff >= ONE_Q16) ? '0 : (ONE_Q16 - h_ff);
      else             g_raw = h_ff;
      g_val = (g_raw > ONE_Q16) ? ONE_Q16 : g_raw;
      case (profile_ff)
         PROF_SQUARED: r_in = pf_ff[6].sq;
         PROF_SINE:    r_in = R_W'(g_val);
         default:      r_in = pf_ff[6].lin;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) r_ff <= r_in;
   end

   // ---------------------------------------------------------------- blend
   logic signed [NUM_W-1:0] num_ff [0:2];
   logic        [COLOR_W-1:0] out_ff [0:2];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic signed [COLOR_W+1:0] diff;
      logic signed [R_W:0]       r_s;
      logic signed [NUM_W-1:0]   num_in;
      logic        [COLOR_W-1:0] out_in;

      always_comb begin
         diff   = $signed({2'b00, end_ff[c]}) - $signed({2'b00, start_ff[c]});
         r_s    = $signed({1'b0, r_ff});
         num_in = $signed(NUM_W'({start_ff[c], 16'h0000}))
                + NUM_W'(diff) * NUM_W'(r_s);
         if (num_ff[c][NUM_W-1]) out_in = '0;
         else if (num_ff[c][NUM_W-2:FRAC_W] > (NUM_W-1-FRAC_W)'(255)) out_in = 8'd255;
         else out_in = num_ff[c][FRAC_W+7:FRAC_W];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[c] <= num_in;
            out_ff[c] <= out_in;
         end
      end
   end

   assign rsp_ch.valid     = vld_ff[N_STG-1];
   assign rsp_ch.red_out   = out_ff[0];
   assign rsp_ch.green_out = out_ff[1];
   assign rsp_ch.blue_out  = out_ff[2];

`ifndef SYNTHESIS
   // a stalled output with a full input stage must block the input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready && vld_ff[0] |-> !req_ch.ready)
      else $error("input accepted over a full stalled pipeline");

   // divider remainder stays below the divisor where its quotient is used
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_DIV] && !dfl_ff[Q_W].sat_lin && !dfl_ff[Q_W].zero
      |-> drem_ff[Q_W] < den_ff)
      else $error("divider remainder out of range");

   // the chosen ratio never exceeds the saturation limit
   a_ratio_max: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RATIO] |-> r_ff <= RATIO_MAX)
      else $error("ratio above saturation limit");
`endif

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench of the radial gradient pixel colour block
`timescale 1ns / 100ps
module tb;
   import rgpc_pkg::*;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } pixel_t;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_t;

   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 100;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rgpc_req_if req_bus ();
   rgpc_rsp_if rsp_bus ();

   radial_gradient_pixel_color_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // testbench copy of the gradient settings
   logic [7:0]  start_rgb [0:2];
   logic [7:0]  end_rgb [0:2];
   logic [11:0] grad_size;
   logic [1:0]  grad_profile;

   pixel_t  pixel_q [$];
   colour_t colour_q [$];
   bit      failed;
   bit      idle_on;
   bit      req_taken;
   int      req_gap;
   int      rsp_gap;
   int      quiet_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned isqrt64(longint unsigned n);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // (1 - cos(pi*v)) / 2 for v up to one half, q16 in and out
   function automatic longint unsigned half_versine(longint unsigned v);
      longint unsigned w;
      longint unsigned t;
      w = v * v;
      t = 64'd27709939;
      t = 64'd252684340 - ((t * w) >> 32);
      t = 64'd1433727482 - ((t * w) >> 32);
      t = 64'd4358008962 - ((t * w) >> 32);
      t = 64'd5298703516 - ((t * w) >> 32);
      return (t * w + (64'd1 << 46)) >> 47;
   endfunction

   function automatic longint unsigned sine_shape(longint unsigned lin);
      longint unsigned p;
      longint unsigned u;
      longint unsigned g;
      longint unsigned h;
      p = lin & 64'h1FFFF;
      u = (p <= 64'h10000) ? p : 64'h20000 - p;
      if (u <= 64'h8000) begin
         g = half_versine(u);
      end else begin
         h = half_versine(64'h10000 - u);
         g = (h >= 64'h10000) ? 0 : 64'h10000 - h;
      end
      return (g > 64'h10000) ? 64'h10000 : g;
   endfunction

   function automatic colour_t gradient_colour(pixel_t px);
      longint unsigned d2;
      longint unsigned den;
      longint unsigned ip;
      longint unsigned rem;
      longint unsigned lin;
      longint unsigned sq;
      longint unsigned ratio;
      longint unsigned sat;
      longint num;
      logic [7:0] ch [0:2];
      sat = 64'd255 << 16;
      d2 = longint'(px.x) * px.x + longint'(px.y) * px.y;
      den = 2 * longint'(grad_size) * grad_size;
      if (den == 0) begin
         lin = (d2 == 0) ? 0 : sat;
         sq = lin;
      end else begin
         ip = d2 / den;
         rem = d2 % den;
         if (ip >= 65025) lin = sat;
         else lin = isqrt64((ip << 32) + ((rem << 32) / den));
         if (lin > sat) lin = sat;
         if (ip >= 255) sq = sat;
         else sq = (ip << 16) + ((rem << 16) / den);
      end
      if (grad_profile == PROF_SQUARED) ratio = sq;
      else if (grad_profile == PROF_SINE) ratio = sine_shape(lin);
      else ratio = lin;
      for (int i = 0; i < 3; i++) begin
         num = longint'(start_rgb[i]) * 65536
             + (longint'(end_rgb[i]) - longint'(start_rgb[i])) * longint'(ratio);
         num = num / 65536;
         ch[i] = (num < 0) ? 8'd0 : (num > 255) ? 8'd255 : num[7:0];
      end
      return '{red: ch[0], green: ch[1], blue: ch[2]};
   endfunction

   // ---------------------------------------------------------------- driver

   // new items and idle bursts are set up at the falling edge
   always @(negedge clock) begin
      logic   v;
      pixel_t px;
      logic   rdy;
      v = req_bus.valid;
      px = {req_bus.x_pos, req_bus.y_pos};
      if (reset) begin
         v = 1'b0;
      end else if (!v || req_taken) begin
         v = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 6);
         end else if (pixel_q.size() > 0) begin
            px = pixel_q.pop_front();
            v = 1'b1;
         end
      end
      req_bus.valid <= v;
      req_bus.x_pos <= px.x;
      req_bus.y_pos <= px.y;

      // result side stalls in bursts too
      rdy = 1'b1;
      if (rsp_gap > 0) begin
         rsp_gap--;
         rdy = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_gap = $urandom_range(0, 6);
         rdy = 1'b0;
      end
      rsp_bus.ready <= rdy;
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      colour_t got;
      colour_t want;
      bit      moved;
      bit      taken;
      moved = 1'b0;
      taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            colour_q.push_back(gradient_colour({req_bus.x_pos, req_bus.y_pos}));
            taken = 1'b1;
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            got = {rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out};
            if (colour_q.size() == 0) begin
               $display("%0t: colour item with none expected: actual %h", $time, got);
               failed = 1'b1;
            end else begin
               want = colour_q.pop_front();
               if (got.red !== want.red)
                  $display("%0t: red mismatch: expected %0d actual %0d",
                           $time, want.red, got.red);
               if (got.green !== want.green)
                  $display("%0t: green mismatch: expected %0d actual %0d",
                           $time, want.green, got.green);
               if (got.blue !== want.blue)
                  $display("%0t: blue mismatch: expected %0d actual %0d",
                           $time, want.blue, got.blue);
               if (got !== want) failed = 1'b1;
            end
         end
         // watchdog on cycles with no item moving
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
      req_taken <= taken;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      // mirror with masking to register width
      case (idx)
         REG_START_RED:   start_rgb[0] = data[7:0];
         REG_START_GREEN: start_rgb[1] = data[7:0];
         REG_START_BLUE:  start_rgb[2] = data[7:0];
         REG_END_RED:     end_rgb[0] = data[7:0];
         REG_END_GREEN:   end_rgb[1] = data[7:0];
         REG_END_BLUE:    end_rgb[2] = data[7:0];
         REG_SIZE:        grad_size = data;
         REG_PROFILE:     grad_profile = data[1:0];
         default: ;
      endcase
   endtask

   // colour write with junk in the unused upper bits
   function automatic logic [CSR_DATA_W-1:0] colour_word(input logic [7:0] c);
      return {4'($urandom), c};
   endfunction

   task automatic set_gradient(input logic [7:0] s_r, s_g, s_b, e_r, e_g, e_b,
                               input logic [11:0] sz, input logic [1:0] prof);
      csr_write(REG_START_RED, colour_word(s_r));
      csr_write(REG_START_GREEN, colour_word(s_g));
      csr_write(REG_START_BLUE, colour_word(s_b));
      csr_write(REG_END_RED, colour_word(e_r));
      csr_write(REG_END_GREEN, colour_word(e_g));
      csr_write(REG_END_BLUE, colour_word(e_b));
      csr_write(REG_SIZE, sz);
      csr_write(REG_PROFILE, {10'($urandom), prof});
   endtask

   // mostly coordinates near the gradient radius, some across the full range
   task automatic queue_random(input int count);
      int reach;
      pixel_t px;
      reach = (grad_size == 0) ? 4 : grad_size + grad_size / 2 + 1;
      if (reach > 4095) reach = 4095;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: px = {COORD_BITS'($urandom), COORD_BITS'($urandom)};
            1: px = {COORD_BITS'(grad_size), COORD_BITS'(grad_size)};
            2: px = {COORD_BITS'($urandom_range(0, 1) ? 4095 : 0),
                     COORD_BITS'($urandom_range(0, 1) ? 4095 : 0)};
            default: px = {COORD_BITS'($urandom_range(0, reach)),
                           COORD_BITS'($urandom_range(0, reach))};
         endcase
         pixel_q.push_back(px);
      end
   endtask

   // wait for every expected colour, then for the pipeline to settle
   task automatic drain();
      while (pixel_q.size() > 0 || req_bus.valid || colour_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.x_pos = '0;
      req_bus.y_pos = '0;
      rsp_bus.ready = 1'b0;
      req_taken = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      quiet_cycles = 0;
      failed = 1'b0;
      idle_on = 1'b1;
      start_rgb = '{8'd255, 8'd255, 8'd255};
      end_rgb = '{8'd0, 8'd255, 8'd0};
      grad_size = 12'd500;
      grad_profile = 2'd0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, origin, far corner, range extremes
      pixel_q.push_back({12'd0, 12'd0});
      pixel_q.push_back({12'd500, 12'd500});
      pixel_q.push_back({12'd4095, 12'd4095});
      pixel_q.push_back({12'd4095, 12'd0});
      pixel_q.push_back({12'd0, 12'd4095});
      pixel_q.push_back({12'd250, 12'd250});
      pixel_q.push_back({12'd707, 12'd0});
      pixel_q.push_back({12'hAAA, 12'h555});
      pixel_q.push_back({12'h555, 12'hAAA});
      drain();

      // directed: each profile, zero size and the unnamed fourth profile
      for (int p = 0; p < 4; p++) begin
         set_gradient(8'd0, 8'd255, 8'd17, 8'd255, 8'd0, 8'd200, 12'd300, 2'(p));
         pixel_q.push_back({12'd0, 12'd0});
         pixel_q.push_back({12'd300, 12'd300});
         pixel_q.push_back({12'd150, 12'd150});
         pixel_q.push_back({12'd600, 12'd600});
         drain();
      end
      set_gradient(8'd10, 8'd20, 8'd30, 8'd240, 8'd250, 8'd0, 12'd0, 2'd2);
      pixel_q.push_back({12'd0, 12'd0});
      pixel_q.push_back({12'd1, 12'd0});
      pixel_q.push_back({12'd4095, 12'd4095});
      drain();

      // random phases over sizes and profiles, extremes included
      for (int ph = 0; ph < 10; ph++) begin
         logic [11:0] sz;
         case (ph)
            0: sz = 12'd1;
            1: sz = 12'd4095;
            2: sz = 12'd0;
            3: sz = 12'd2;
            default: sz = 12'($urandom_range(1, 1200));
         endcase
         if (ph == 9) idle_on = 1'b0;
         if (ph < 2)
            set_gradient(ph ? 8'd255 : 8'd0, ph ? 8'd0 : 8'd255, 8'd255,
                         ph ? 8'd0 : 8'd255, ph ? 8'd255 : 8'd0, 8'd0, sz, 2'(ph));
         else
            set_gradient(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), sz, 2'($urandom_range(0, 3)));
         queue_random(60);
         drain();
      end

      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
